// ----- src/prs_pkg.sv -----
`timescale 1ns / 1ps

package prs_pkg;

	// fixed field widths of the stream words
	localparam int ACTION_W  = 2;
	localparam int FIELD_W   = 16;
	localparam int INDEX_W   = 10;
	localparam int S_TDATA_W = 2 * FIELD_W;
	localparam int M_TDATA_W = 16;

	typedef enum logic [ACTION_W-1:0] {
		ACT_APPEND = 2'd0,
		ACT_DRAW   = 2'd1,
		ACT_CLEAR  = 2'd2
	} action_t;

endpackage

// ----- src/particle_resampling_selector.sv -----
`timescale 1ns / 1ps

// append and clear words are taken in idle and leave the block ready
// draw: the uniform is scaled by the total in MUL_LO and MUL_HI, then a binary search
// of the cumulative table does one read and compare per cycle until the range closes
// a draw on an empty table or zero total skips to DONE with empty_error set and index 0
// input is held off from a draw until its result is in the output register
// arst_n clears control, count and total; the table itself is not cleared

module particle_resampling_selector #(
	parameter int MAX_PARTICLES = 1024,
	parameter int WEIGHT_BITS   = 16,
	parameter int RANDOM_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// weight, uniform
	input  logic [prs_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// action
	input  logic [prs_pkg::ACTION_W-1:0]  s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// particle_index
	output logic [prs_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// empty_error
	output logic [0:0]                    m_axis_tuser
);
	import prs_pkg::*;

	localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
	localparam int SUM_W = WEIGHT_BITS + IDX_W;
	localparam int WE_W  = (WEIGHT_BITS < FIELD_W) ? WEIGHT_BITS : FIELD_W;
	localparam int U_W   = (RANDOM_BITS < FIELD_W) ? RANDOM_BITS : FIELD_W;
	localparam int HALF  = (SUM_W + 1) / 2;
	localparam int MP_W  = U_W + HALF;
	localparam int PW    = U_W + SUM_W;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_MUL_LO = 5'b00010,
		ST_MUL_HI = 5'b00100,
		ST_SEARCH = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t state_q;

	logic [SUM_W-1:0] mem [MAX_PARTICLES];

	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] total_q;
	logic [U_W-1:0]   u_q;
	logic [PW-1:0]    prod_q;
	logic [SUM_W-1:0] target_q;
	logic [SUM_W-1:0] rdata_q;
	logic [IDX_W-1:0] lo_q, hi_q, mid_q;
	logic [INDEX_W-1:0] res_idx_q;
	logic             res_err_q;
	logic             m_valid_q;
	logic [INDEX_W-1:0] m_idx_q;
	logic             m_err_q;

	logic [WE_W-1:0]  w_in;
	logic [U_W-1:0]   u_in;
	logic [SUM_W-1:0] new_total;
	logic             in_fire, out_free, full;
	logic             wr_en, rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [HALF-1:0]  mul_b;
	logic [MP_W-1:0]  mul_p;
	logic [PW-1:0]    prod_sum;
	logic             gt;
	logic [IDX_W-1:0] nlo, nhi, nmid, mid0;

	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_free  = !m_valid_q || m_axis_tready;
	assign full      = (cnt_q >= CNT_W'(MAX_PARTICLES));
	assign w_in      = s_axis_tdata[WE_W-1:0];
	assign u_in      = s_axis_tdata[FIELD_W +: U_W];
	assign new_total = total_q + SUM_W'(w_in);
	assign wr_en     = in_fire && (action_t'(s_axis_tuser) == ACT_APPEND) && !full;

	// shared multiplier: low half of the total, then the high half
	always_comb begin
		mul_b = '0;
		if (state_q == ST_MUL_LO) begin
			mul_b = total_q[HALF-1:0];
		end else begin
			mul_b = HALF'(total_q >> HALF);
		end
	end
	assign mul_p    = MP_W'(u_q) * MP_W'(mul_b);
	assign prod_sum = prod_q + (PW'(mul_p) << HALF);

	// search step and next probe address
	assign gt   = rdata_q > target_q;
	assign nlo  = gt ? lo_q : mid_q + IDX_W'(1);
	assign nhi  = gt ? mid_q : hi_q;
	assign nmid = IDX_W'(({1'b0, nlo} + {1'b0, nhi}) >> 1);
	assign mid0 = IDX_W'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = mid0;
		if (state_q == ST_MUL_HI) begin
			rd_en = 1'b1;
		end else if (state_q == ST_SEARCH) begin
			rd_en   = 1'b1;
			rd_addr = nmid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[cnt_q[IDX_W-1:0]] <= new_total;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			total_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (action_t'(s_axis_tuser))
							ACT_APPEND: begin
								if (!full) begin
									total_q <= new_total;
									cnt_q   <= cnt_q + CNT_W'(1);
								end
							end
							ACT_CLEAR: begin
								total_q <= '0;
								cnt_q   <= '0;
							end
							ACT_DRAW: begin
								if (cnt_q == '0 || total_q == '0) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_MUL_LO;
								end
							end
							default: ;
						endcase
					end
				end
				ST_MUL_LO: state_q <= ST_MUL_HI;
				ST_MUL_HI: begin
					if (lo_q == hi_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (nlo == nhi) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				u_q       <= u_in;
				lo_q      <= '0;
				hi_q      <= IDX_W'(cnt_q - CNT_W'(1));
				res_idx_q <= '0;
				res_err_q <= 1'b1;
			end
			ST_MUL_LO: begin
				prod_q <= PW'(mul_p);
			end
			ST_MUL_HI: begin
				target_q  <= SUM_W'(prod_sum >> RANDOM_BITS);
				mid_q     <= mid0;
				res_idx_q <= INDEX_W'(lo_q);
				res_err_q <= 1'b0;
			end
			ST_SEARCH: begin
				lo_q      <= nlo;
				hi_q      <= nhi;
				mid_q     <= nmid;
				res_idx_q <= INDEX_W'(nlo);
			end
			ST_DONE: begin
				if (out_free) begin
					m_idx_q <= res_idx_q;
					m_err_q <= res_err_q;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = M_TDATA_W'(m_idx_q);
	assign m_axis_tuser  = m_err_q;

endmodule

// ----- src/prs_chk.sv -----
`timescale 1ns / 1ps

module prs_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic [prs_pkg::S_TDATA_W-1:0] s_axis_tdata,
	input logic [prs_pkg::ACTION_W-1:0]  s_axis_tuser,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [prs_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic [0:0]                    m_axis_tuser
);
	import prs_pkg::*;

	logic in_fire;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	// a waiting result word is not dropped
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result word dropped while stalled");

	a_err_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("error result with nonzero index");

	// a draw occupies the block
	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && s_axis_tuser == ACT_DRAW |=> !s_axis_tready)
		else $error("input taken during a draw");

	// table updates never stall the input
	a_upd_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && (s_axis_tuser == ACT_APPEND || s_axis_tuser == ACT_CLEAR)
		|=> s_axis_tready)
		else $error("not ready after append or clear");

endmodule

bind particle_resampling_selector prs_chk u_prs_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import prs_pkg::*;

	localparam int MAX_P          = 1024;
	localparam int RAND_WORDS     = 1200;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int DRAIN_CYCLES   = 40;
	localparam logic [ACTION_W-1:0] ACT_UNDEF = 2'd3;

	typedef struct packed {
		logic [INDEX_W-1:0] idx;
		logic               err;
	} draw_result_t;

	typedef struct packed {
		logic [ACTION_W-1:0] act;
		logic [FIELD_W-1:0]  weight;
		logic [FIELD_W-1:0]  uniform;
		bit                  typed;
		logic [INDEX_W-1:0]  idx;
		logic                err;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [ACTION_W-1:0]  s_axis_tuser = ACT_APPEND;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [0:0]           m_axis_tuser;

	// shadow of the cumulative weight table
	logic [25:0]  cum_table [MAX_P];
	int unsigned  n_entries = 0;
	logic [25:0]  weight_sum = '0;
	draw_result_t pending_draws [$];

	int  errors = 0;
	int  cycles = 0;
	int  random_words = 0;
	bit  calm = 1'b0;

	// directed rows; typed expectations only where obvious
	stim_row_t directed_rows [25] = '{
		'{ACT_DRAW,   16'h0000, 16'h1234, 1'b1, 10'd0, 1'b1},  // empty after reset
		'{ACT_APPEND, 16'h0000, 16'h0000, 1'b0, 10'd0, 1'b0},
		'{ACT_DRAW,   16'h0000, 16'hFFFF, 1'b1, 10'd0, 1'b1},  // entries but zero total
		'{ACT_APPEND, 16'hFFFF, 16'h0000, 1'b0, 10'd0, 1'b0},
		'{ACT_APPEND, 16'h0000, 16'hFFFF, 1'b0, 10'd0, 1'b0},
		'{ACT_APPEND, 16'h0001, 16'h0000, 1'b0, 10'd0, 1'b0},
		'{ACT_DRAW,   16'hFFFF, 16'h0000, 1'b1, 10'd1, 1'b0},  // zero weight at 0 skipped
		'{ACT_DRAW,   16'h0000, 16'hFFFF, 1'b1, 10'd3, 1'b0},  // top of range
		'{ACT_DRAW,   16'h0000, 16'h8000, 1'b0, 10'd0, 1'b0},
		'{ACT_UNDEF,  16'hFFFF, 16'hFFFF, 1'b0, 10'd0, 1'b0},  // ignored
		'{ACT_DRAW,   16'h5555, 16'hAAAA, 1'b0, 10'd0, 1'b0},
		'{ACT_CLEAR,  16'hFFFF, 16'hFFFF, 1'b0, 10'd0, 1'b0},
		'{ACT_DRAW,   16'h0000, 16'h5555, 1'b1, 10'd0, 1'b1},  // empty after clear
		'{ACT_APPEND, 16'h0001, 16'h0000, 1'b0, 10'd0, 1'b0},
		'{ACT_DRAW,   16'h0000, 16'hFFFF, 1'b1, 10'd0, 1'b0},  // single entry
		'{ACT_APPEND, 16'hFFFF, 16'h0000, 1'b0, 10'd0, 1'b0},
		'{ACT_DRAW,   16'h0000, 16'h0001, 1'b0, 10'd0, 1'b0},
		'{ACT_APPEND, 16'h5A5A, 16'h0000, 1'b0, 10'd0, 1'b0},
		'{ACT_APPEND, 16'hA5A5, 16'h0000, 1'b0, 10'd0, 1'b0},
		'{ACT_DRAW,   16'h0000, 16'hC000, 1'b0, 10'd0, 1'b0},
		'{ACT_DRAW,   16'h0000, 16'h3FFF, 1'b0, 10'd0, 1'b0},
		'{ACT_CLEAR,  16'h0000, 16'h0000, 1'b0, 10'd0, 1'b0},
		'{ACT_APPEND, 16'h0000, 16'h0000, 1'b0, 10'd0, 1'b0},
		'{ACT_APPEND, 16'h0000, 16'h0000, 1'b0, 10'd0, 1'b0},
		'{ACT_DRAW,   16'h0000, 16'h7777, 1'b1, 10'd0, 1'b1}   // zero total again
	};

	particle_resampling_selector u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// update the table and work out the draw result for one accepted word
	function automatic void update_cdf_and_draw(logic [ACTION_W-1:0] act,
			logic [FIELD_W-1:0] w, logic [FIELD_W-1:0] u, bit typed,
			logic [INDEX_W-1:0] t_idx, logic t_err);
		draw_result_t r;
		logic [41:0]  target;
		int unsigned  lo, hi, mid;
		case (act)
			ACT_APPEND: begin
				if (n_entries < MAX_P) begin
					weight_sum = weight_sum + 26'(w);
					cum_table[n_entries] = weight_sum;
					n_entries++;
				end
			end
			ACT_CLEAR: begin
				n_entries = 0;
				weight_sum = '0;
			end
			ACT_DRAW: begin
				if (n_entries == 0 || weight_sum == 0) begin
					r.idx = '0;
					r.err = 1'b1;
				end else begin
					// target = floor(u * total / 2^16)
					target = (42'(u) * 42'(weight_sum)) >> FIELD_W;
					lo = 0;
					hi = n_entries - 1;
					while (lo < hi) begin
						mid = lo + (hi - lo) / 2;
						if (42'(cum_table[mid]) > target)
							hi = mid;
						else
							lo = mid + 1;
					end
					r.idx = lo[INDEX_W-1:0];
					r.err = 1'b0;
				end
				if (typed) begin
					r.idx = t_idx;
					r.err = t_err;
				end
				pending_draws = {pending_draws, r};
			end
			default: ;
		endcase
	endfunction

	task automatic send_word(input logic [ACTION_W-1:0] act, input logic [FIELD_W-1:0] w,
			input logic [FIELD_W-1:0] u, input bit typed = 1'b0,
			input logic [INDEX_W-1:0] t_idx = '0, input logic t_err = 1'b0);
		int gap;
		gap = 0;
		calm = (random_words >= 300 && random_words < 450);
		if (!calm)
			while ($urandom_range(99) < 29) gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {u, w};
		s_axis_tuser  <= act;
		do @(posedge clk); while (!s_axis_tready);
		update_cdf_and_draw(act, w, u, typed, t_idx, t_err);
		if (act != ACT_UNDEF)
			random_words++;
	endtask

	function automatic logic [FIELD_W-1:0] pick_weight(int mode);
		case (mode)
			0: return FIELD_W'($urandom);
			1: return FIELD_W'($urandom_range(0, 15));
			2: return ($urandom_range(4) == 0) ? FIELD_W'($urandom) : '0;
			3: return ($urandom_range(1) == 0) ? 16'hFFFF : 16'h0000;
			default: return FIELD_W'($urandom_range(0, 65535) >> $urandom_range(0, 15));
		endcase
	endfunction

	function automatic logic [FIELD_W-1:0] pick_uniform();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return FIELD_W'($urandom);
		endcase
	endfunction

	// one run of appends (with the odd draw or undefined word) followed by draws, usually after a clear
	task automatic run_session(input bit fill);
		int n_words, n_draws, mode, k;
		if (fill || $urandom_range(9) < 8)
			send_word(ACT_CLEAR, FIELD_W'($urandom), FIELD_W'($urandom));
		if (fill)
			n_words = MAX_P + $urandom_range(1, 8);
		else
			case ($urandom_range(19))
				0: n_words = 0;
				1, 2, 3, 4: n_words = $urandom_range(17, 200);
				default: n_words = $urandom_range(1, 16);
			endcase
		mode = fill ? 3 : $urandom_range(4);
		for (k = 0; k < n_words; k++) begin
			send_word(ACT_APPEND, pick_weight(mode), FIELD_W'($urandom));
			if ($urandom_range(fill ? 49 : 9) == 0)
				send_word(ACT_DRAW, FIELD_W'($urandom), pick_uniform());
			if ($urandom_range(49) == 0)
				send_word(ACT_UNDEF, FIELD_W'($urandom), FIELD_W'($urandom));
		end
		n_draws = $urandom_range(1, 10);
		for (k = 0; k < n_draws; k++)
			send_word(ACT_DRAW, FIELD_W'($urandom), pick_uniform());
	endtask

	// result word checker and receiver back-pressure
	always @(posedge clk) begin
		draw_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_draws.size() == 0) begin
				$error("unexpected result word: particle_index %0d empty_error %0d",
					m_axis_tdata, m_axis_tuser);
				errors++;
			end else begin
				want = pending_draws.pop_front();
				if (m_axis_tdata !== {{(M_TDATA_W-INDEX_W){1'b0}}, want.idx}) begin
					$error("particle_index: expected %0d, got %0d", want.idx, m_axis_tdata);
					errors++;
				end
				if (m_axis_tuser[0] !== want.err) begin
					$error("empty_error: expected %0d, got %0d", want.err, m_axis_tuser[0]);
					errors++;
				end
			end
		end
		m_axis_tready <= calm || ($urandom_range(99) >= 29);
	end

	initial begin
		int i;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < 25; i++)
			send_word(directed_rows[i].act, directed_rows[i].weight, directed_rows[i].uniform,
				directed_rows[i].typed, directed_rows[i].idx, directed_rows[i].err);

		// one session past a full table, then mostly short runs
		run_session(1'b1);
		while (random_words < RAND_WORDS)
			run_session(1'b0);

		s_axis_tvalid <= 1'b0;
		while (pending_draws.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- particle_resampling_selector.f -----
src/prs_pkg.sv
src/particle_resampling_selector.sv
src/prs_chk.sv
dv/tb_top.sv
